FILE: src/apbb_pkg.sv
//------------------------------------------------------------------------------
// Affine points bounding box package
// Widths, register indexes and reset values shared by the interfaces and
// the top level.
//------------------------------------------------------------------------------
`default_nettype none

package apbb_pkg;

  // Q16.16 coordinates and coefficients.
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * COORD_W;
  // Two products plus the shifted offset need two extra bits to stay exact.
  localparam int SUM_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_YX  = 3'd1,
    REG_COEF_XY  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_idx_t;

  localparam coord_t COEF_ONE  = 32'sh0001_0000;
  localparam coord_t COEF_ZERO = 32'sh0000_0000;
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

FILE: src/apbb_if.sv
//------------------------------------------------------------------------------
// Affine points bounding box channel interfaces
// Valid/ready channels for input points, result boxes and register writes.
//------------------------------------------------------------------------------
`default_nettype none

interface apbb_point_if;
  import apbb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface apbb_box_if;
  import apbb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_max_x;
  coord_t box_max_y;

  modport source (output valid, output box_min_x, output box_min_y,
                  output box_max_x, output box_max_y, input ready);
  modport sink   (input valid, input box_min_x, input box_min_y,
                  input box_max_x, input box_max_y, output ready);
endinterface

interface apbb_cfg_if;
  import apbb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [COORD_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: src/affine_points_bounding_box_unit.sv
//------------------------------------------------------------------------------
// Affine points bounding box unit
// Maps Q16.16 points through a 2x3 affine transform and tracks the min/max
// box of each run of points; the box is sent on the run's last point.
//------------------------------------------------------------------------------
// The box register loads as the last point leaves the map stage.
// Throughput: one point per cycle; the four 32x32 multipliers, the exact
// sum/floor/saturate stage and the min/max compare are each one stage.
// The whole pipeline holds only while a finished box waits on the output.
// Reset (rst_n low, synchronous) loads the identity transform, empties the
// pipeline and makes the next point start a new run.
`default_nettype none

module affine_points_bounding_box_unit (
  input  wire           clk,
  input  wire           rst_n,
  apbb_point_if.sink    in_pt,
  apbb_box_if.source    out_box,
  apbb_cfg_if.sink      cfg_wr
);
  import apbb_pkg::*;

  // Configuration registers.
  coord_t coef_xx_r, coef_yx_r, coef_xy_r, coef_yy_r, offset_x_r, offset_y_r;

  // Stage 1: input register.
  logic   s1_valid_r, s1_last_r;
  coord_t s1_px_r, s1_py_r;

  // Stage 2: products.
  logic   s2_valid_r, s2_last_r;
  prod_t  s2_xx_r, s2_xy_r, s2_yx_r, s2_yy_r;

  // Stage 3: mapped point.
  logic   s3_valid_r, s3_last_r;
  coord_t s3_tx_r, s3_ty_r;

  // Running bounds.
  logic   run_start_r;
  coord_t run_min_x_r, run_min_y_r, run_max_x_r, run_max_y_r;
  coord_t run_min_x_nxt, run_min_y_nxt, run_max_x_nxt, run_max_y_nxt;

  // Output register.
  logic   out_valid_r;
  coord_t box_min_x_r, box_min_y_r, box_max_x_r, box_max_y_r;

  logic   advance;
  logic   in_beat;
  coord_t tx_nxt, ty_nxt;

  // Exact sum of two products and the shifted offset, floored back to
  // Q16.16 and saturated to the 32-bit range.
  function automatic coord_t axis_sat(input prod_t pa, input prod_t pb,
                                      input coord_t off);
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-FRAC_W-1:0] q;
    sum = SUM_W'(pa) + SUM_W'(pb) + (SUM_W'(off) <<< FRAC_W);
    q   = sum[SUM_W-1:FRAC_W];
    if ((q[SUM_W-FRAC_W-1:COORD_W-1] == '0) || (q[SUM_W-FRAC_W-1:COORD_W-1] == '1)) begin
      return q[COORD_W-1:0];
    end else if (q[SUM_W-FRAC_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  // Everything moves together unless a box is waiting to be taken.
  assign advance      = !out_valid_r || out_box.ready;
  assign in_pt.ready  = advance;
  assign in_beat      = in_pt.valid && advance;
  assign cfg_wr.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r  <= COEF_ONE;
      coef_yx_r  <= COEF_ZERO;
      coef_xy_r  <= COEF_ZERO;
      coef_yy_r  <= COEF_ONE;
      offset_x_r <= COEF_ZERO;
      offset_y_r <= COEF_ZERO;
    end else if (cfg_wr.valid) begin
      case (cfg_idx_t'(cfg_wr.reg_index))
        REG_COEF_XX:  coef_xx_r  <= coord_t'(cfg_wr.wdata);
        REG_COEF_YX:  coef_yx_r  <= coord_t'(cfg_wr.wdata);
        REG_COEF_XY:  coef_xy_r  <= coord_t'(cfg_wr.wdata);
        REG_COEF_YY:  coef_yy_r  <= coord_t'(cfg_wr.wdata);
        REG_OFFSET_X: offset_x_r <= coord_t'(cfg_wr.wdata);
        REG_OFFSET_Y: offset_y_r <= coord_t'(cfg_wr.wdata);
        default: ;
      endcase
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_beat;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px_r   <= in_pt.point_x;
      s1_py_r   <= in_pt.point_y;
      s1_last_r <= in_pt.last_point;

      s2_xx_r   <= s1_px_r * coef_xx_r;
      s2_xy_r   <= s1_py_r * coef_xy_r;
      s2_yx_r   <= s1_px_r * coef_yx_r;
      s2_yy_r   <= s1_py_r * coef_yy_r;
      s2_last_r <= s1_last_r;

      s3_tx_r   <= tx_nxt;
      s3_ty_r   <= ty_nxt;
      s3_last_r <= s2_last_r;
    end
  end

  assign tx_nxt = axis_sat(s2_xx_r, s2_xy_r, offset_x_r);
  assign ty_nxt = axis_sat(s2_yx_r, s2_yy_r, offset_y_r);

  // Bounds update; ties keep the held bound.
  always_comb begin
    if (run_start_r) begin
      run_min_x_nxt = s3_tx_r;
      run_max_x_nxt = s3_tx_r;
      run_min_y_nxt = s3_ty_r;
      run_max_y_nxt = s3_ty_r;
    end else begin
      run_min_x_nxt = (s3_tx_r < run_min_x_r) ? s3_tx_r : run_min_x_r;
      run_max_x_nxt = (s3_tx_r > run_max_x_r) ? s3_tx_r : run_max_x_r;
      run_min_y_nxt = (s3_ty_r < run_min_y_r) ? s3_ty_r : run_min_y_r;
      run_max_y_nxt = (s3_ty_r > run_max_y_r) ? s3_ty_r : run_max_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_start_r <= 1'b1;
      run_min_x_r <= COEF_ZERO;
      run_min_y_r <= COEF_ZERO;
      run_max_x_r <= COEF_ZERO;
      run_max_y_r <= COEF_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s3_valid_r && s3_last_r;
      end
      if (advance && s3_valid_r) begin
        run_start_r <= s3_last_r;
        run_min_x_r <= run_min_x_nxt;
        run_min_y_r <= run_min_y_nxt;
        run_max_x_r <= run_max_x_nxt;
        run_max_y_r <= run_max_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid_r && s3_last_r) begin
      box_min_x_r <= run_min_x_nxt;
      box_min_y_r <= run_min_y_nxt;
      box_max_x_r <= run_max_x_nxt;
      box_max_y_r <= run_max_y_nxt;
    end
  end

  assign out_box.valid     = out_valid_r;
  assign out_box.box_min_x = box_min_x_r;
  assign out_box.box_min_y = box_min_y_r;
  assign out_box.box_max_x = box_max_x_r;
  assign out_box.box_max_y = box_max_y_r;

  // A box appears only for the last point of a run leaving the map stage.
  a_box_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r && s3_last_r))
    else $error("box beat without a last point");

  // While a box is stalled, the running min x, max y and run start must not move.
  a_bounds_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_box.ready) |=> ($stable(run_min_x_r) && $stable(run_max_y_r)
                                         && $stable(run_start_r)))
    else $error("running bounds changed during output stall");

  // Inside a run the bounds are ordered.
  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !run_start_r |-> ((run_min_x_r <= run_max_x_r) && (run_min_y_r <= run_max_y_r)))
    else $error("running bounds out of order");

  // Every box sent is ordered.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((box_min_x_r <= box_max_x_r) && (box_min_y_r <= box_max_y_r)))
    else $error("output box out of order");

endmodule

`default_nettype wire

FILE: tb/affine_points_bounding_box_unit_test.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Affine points bounding box unit test
// Streams runs of Q16.16 points through the unit under several transforms
// and handshake idling patterns. A scoreboard maps every accepted point
// with its own copy of the transform registers, keeps the running box of
// each run and checks every box beat against the oldest pending box.
//------------------------------------------------------------------------------

module affine_points_bounding_box_unit_test;
  import apbb_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 10;
  localparam int PIPE_LATENCY    = 4;
  localparam int STUCK_LIMIT     = 5000;
  localparam int NUM_PHASES      = 8;
  localparam int POINTS_PER_PHASE = 180;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  class box_tracker;
    coord_t wxx, wyx, wxy, wyy, shift_x, shift_y;
    coord_t lo_x, lo_y, hi_x, hi_y;
    bit     new_run;
    box_t   pending_boxes[$];
    int     mismatches;

    function new();
      wxx      = COEF_ONE;
      wyx      = COEF_ZERO;
      wxy      = COEF_ZERO;
      wyy      = COEF_ONE;
      shift_x  = COEF_ZERO;
      shift_y  = COEF_ZERO;
      lo_x     = COEF_ZERO;
      lo_y     = COEF_ZERO;
      hi_x     = COEF_ZERO;
      hi_y     = COEF_ZERO;
      new_run  = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, coord_t value);
      case (idx)
        REG_COEF_XX:  wxx = value;
        REG_COEF_YX:  wyx = value;
        REG_COEF_XY:  wxy = value;
        REG_COEF_YY:  wyy = value;
        REG_OFFSET_X: shift_x = value;
        REG_OFFSET_Y: shift_y = value;
        default: ;
      endcase
    endfunction

    // Exact Q34.32 sum, floor back to Q16.16, then clamp to 32 bits.
    function coord_t map_axis(coord_t w1, coord_t v1, coord_t w2, coord_t v2, coord_t off);
      logic signed [SUM_W-1:0] a1, b1, a2, b2, o, s, q, hi, lo;
      a1 = w1;
      b1 = v1;
      a2 = w2;
      b2 = v2;
      o  = off;
      hi = COORD_MAX;
      lo = COORD_MIN;
      s  = a1 * b1 + a2 * b2 + (o <<< FRAC_W);
      q  = s >>> FRAC_W;
      if (q > hi) return COORD_MAX;
      if (q < lo) return COORD_MIN;
      return q[COORD_W-1:0];
    endfunction

    function void note_point(coord_t px, coord_t py, logic last);
      coord_t tx, ty;
      box_t   done;
      tx = map_axis(wxx, px, wxy, py, shift_x);
      ty = map_axis(wyx, px, wyy, py, shift_y);
      if (new_run) begin
        lo_x = tx;
        hi_x = tx;
        lo_y = ty;
        hi_y = ty;
      end else begin
        if (tx < lo_x) lo_x = tx;
        if (ty < lo_y) lo_y = ty;
        if (tx > hi_x) hi_x = tx;
        if (ty > hi_y) hi_y = ty;
      end
      new_run = last;
      if (last) begin
        done = '{lo_x, lo_y, hi_x, hi_y};
        pending_boxes.push_back(done);
      end
    endfunction

    function void compare_field(string name, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_box(box_t got);
      box_t want;
      if (pending_boxes.size() == 0) begin
        $error("box beat with no box pending: min (%0d, %0d) max (%0d, %0d)",
               got.min_x, got.min_y, got.max_x, got.max_y);
        mismatches++;
        return;
      end
      want = pending_boxes.pop_front();
      compare_field("box_min_x", want.min_x, got.min_x);
      compare_field("box_min_y", want.min_y, got.min_y);
      compare_field("box_max_x", want.max_x, got.max_x);
      compare_field("box_max_y", want.max_y, got.max_y);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   stuck_cycles = 0;
  box_tracker tracker = new();

  apbb_point_if pt_ch();
  apbb_box_if   box_ch();
  apbb_cfg_if   cfg_ch();

  affine_points_bounding_box_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (pt_ch),
    .out_box (box_ch),
    .cfg_wr  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      box_ch.ready <= 1'b0;
    end else begin
      box_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Beats are sampled at the edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.reg_index, cfg_ch.wdata);
      if (pt_ch.valid && pt_ch.ready)
        tracker.note_point(pt_ch.point_x, pt_ch.point_y, pt_ch.last_point);
      if (box_ch.valid && box_ch.ready)
        tracker.check_box('{box_ch.box_min_x, box_ch.box_min_y,
                            box_ch.box_max_x, box_ch.box_max_y});
    end
  end

  always @(posedge clk) begin
    if ((pt_ch.valid && pt_ch.ready) || (box_ch.valid && box_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0, 1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return COEF_ZERO;
          default: return -32'sd1;
        endcase
      end
      default: return coord_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endcase
  endfunction

  // Mostly weights within +/-4.0 so that boxes stay away from the clamp.
  function automatic coord_t rand_weight();
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return COEF_ZERO;
          default: return COEF_ONE;
        endcase
      end
      default: return coord_t'($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic send_point(input coord_t px, input coord_t py, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pt_ch.valid      <= 1'b1;
    pt_ch.point_x    <= px;
    pt_ch.point_y    <= py;
    pt_ch.last_point <= last;
    do @(posedge clk); while (!pt_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the sender off until every pending box is out, then lets any
  // points of an unfinished run clear the pipeline.
  task automatic wait_drained();
    pt_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_boxes.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_transform(input coord_t xx, input coord_t yx, input coord_t xy,
                                 input coord_t yy, input coord_t ox, input coord_t oy);
    write_reg(REG_COEF_XX, xx);
    write_reg(REG_COEF_YX, yx);
    write_reg(REG_COEF_XY, xy);
    write_reg(REG_COEF_YY, yy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
  endtask

  initial begin
    int run_len;
    int sent;
    pt_ch.valid      <= 1'b0;
    pt_ch.point_x    <= '0;
    pt_ch.point_y    <= '0;
    pt_ch.last_point <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= '0;
    cfg_ch.wdata     <= '0;
    rst_n            <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity transform out of reset: single-point run, extreme corners, ties.
    send_point(COEF_ZERO, COEF_ZERO, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(32'sd1, -32'sd1, 1'b0);
    send_point(32'sd1, -32'sd1, 1'b1);
    send_point(32'sd5, 32'sd5, 1'b0);
    send_point(32'sd5, 32'sd5, 1'b1);
    wait_drained();

    // Extreme registers drive both axes into the clamp from either side.
    write_transform(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    write_reg(IDX_UNMAPPED_LO, coord_t'($urandom));
    write_reg(IDX_UNMAPPED_HI, coord_t'($urandom));
    send_point(COORD_MIN, COORD_MIN, 1'b1);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COEF_ZERO, COEF_ZERO, 1'b1);
    send_point(-32'sd1, -32'sd1, 1'b1);
    wait_drained();

    // Fractional weights and a negative offset exercise the floor.
    write_transform(32'sh0000_8000, -32'sh0001_0000, -32'sd1, 32'sd3, -32'sd1, 32'sd1);
    send_point(32'sd1, 32'sd1, 1'b1);
    send_point(-32'sd1, COEF_ZERO, 1'b1);
    send_point(32'sd3, -32'sd7, 1'b0);
    send_point(-32'sd3, 32'sd7, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_transform(rand_weight(), rand_weight(), rand_weight(),
                      rand_weight(), rand_weight(), rand_weight());
      if ($urandom_range(1) == 0) write_reg(IDX_UNMAPPED_LO, coord_t'($urandom));
      else write_reg(IDX_UNMAPPED_HI, coord_t'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      sent = 0;
      while (sent < POINTS_PER_PHASE) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (int i = 0; i < run_len; i++) begin
          send_point(rand_coord(), rand_coord(), i == run_len - 1);
          sent++;
        end
        if ($urandom_range(24) == 0) wait_drained();
      end
    end

    wait_drained();
    if (tracker.mismatches == 0 && tracker.pending_boxes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
